@@ hw/rtl/jamc_pkg.sv @@
package jamc_pkg;

  localparam int unsigned AXIS_W   = 8;
  localparam int unsigned CENTRE_W = 8;
  localparam int unsigned DBAND_W  = 7;
  localparam int unsigned CMP_W    = AXIS_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_STICK_CENTRE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 2'd1;

  localparam logic [CENTRE_W-1:0] CENTRE_RESET = 8'd128;
  localparam logic [DBAND_W-1:0]  DBAND_RESET  = 7'd20;

  typedef enum logic [3:0] {
    MODE_INIT       = 4'd0,
    MODE_READY      = 4'd1,
    MODE_LEFT       = 4'd2,
    MODE_RIGHT      = 4'd3,
    MODE_REAR_UP    = 4'd4,
    MODE_REAR_DOWN  = 4'd5,
    MODE_MID_UP     = 4'd6,
    MODE_MID_DOWN   = 4'd7,
    MODE_FRONT_UP   = 4'd8,
    MODE_FRONT_DOWN = 4'd9,
    MODE_CLOSE      = 4'd10,
    MODE_OPEN       = 4'd11
  } mode_t;

  typedef enum logic [1:0] {
    MOTOR_STOP  = 2'd0,
    MOTOR_LEFT  = 2'd1,
    MOTOR_RIGHT = 2'd2
  } motor_t;

  typedef enum logic [1:0] {
    GRIP_NONE  = 2'd0,
    GRIP_CLOSE = 2'd1,
    GRIP_OPEN  = 2'd2
  } grip_t;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_ON    = 2'd1,
    LED_FLASH = 2'd2
  } led_t;

  // one axis against the deadband bounds
  typedef struct packed {
    logic ge_hi;
    logic le_lo;
  } axis_cls_t;

  typedef struct packed {
    logic      start;
    logic      sel;
    logic      l2_press;
    logic      r2_press;
    logic      l2_release;
    logic      r2_release;
    axis_cls_t lx;
    axis_cls_t rx;
    axis_cls_t ly;
    axis_cls_t ry;
  } cls_t;

  typedef struct packed {
    mode_t  mode;
    motor_t base_motor;
    motor_t rear_motor;
    motor_t middle_motor;
    motor_t front_motor;
    grip_t  gripper_cmd;
    led_t   green_led;
    led_t   yellow_led;
    led_t   red_led;
  } res_t;

endpackage

@@ hw/rtl/jamc_front.sv @@
module jamc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jamc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jamc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_start_pressed,
  input  logic                                 in_select_pressed,
  input  logic                                 in_left_trigger_pressed,
  input  logic                                 in_right_trigger_pressed,
  input  logic                                 in_left_trigger_released,
  input  logic                                 in_right_trigger_released,
  input  logic [jamc_pkg::AXIS_W-1:0]          in_left_x,
  input  logic [jamc_pkg::AXIS_W-1:0]          in_right_x,
  input  logic [jamc_pkg::AXIS_W-1:0]          in_left_y,
  input  logic [jamc_pkg::AXIS_W-1:0]          in_right_y,
  output logic                                 cls_valid,
  output jamc_pkg::cls_t                       cls_word,
  input  logic                                 cls_take
);

  logic [jamc_pkg::CENTRE_W-1:0] centre_r;
  logic [jamc_pkg::DBAND_W-1:0]  dband_r;
  logic [jamc_pkg::CMP_W-1:0]    hi;
  logic [jamc_pkg::CMP_W-1:0]    centre_ext;
  jamc_pkg::cls_t                cls_in;

  jamc_pkg::cls_t q_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;
  logic           push_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r <= jamc_pkg::CENTRE_RESET;
      dband_r  <= jamc_pkg::DBAND_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        jamc_pkg::CFG_STICK_CENTRE: centre_r <= cfg_data;
        jamc_pkg::CFG_DEADBAND:     dband_r  <= cfg_data[jamc_pkg::DBAND_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic jamc_pkg::axis_cls_t classify(
    input logic [jamc_pkg::AXIS_W-1:0]  x,
    input logic [jamc_pkg::CMP_W-1:0]   hi_b,
    input logic [jamc_pkg::CMP_W-1:0]   ctr,
    input logic [jamc_pkg::DBAND_W-1:0] db
  );
    jamc_pkg::axis_cls_t c;
    logic [jamc_pkg::CMP_W-1:0] x_ext;
    x_ext   = {1'b0, x};
    c.ge_hi = (x_ext >= hi_b);
    // x <= centre - db, rearranged so nothing goes negative
    c.le_lo = ((x_ext + {{(jamc_pkg::CMP_W-jamc_pkg::DBAND_W){1'b0}}, db}) <= ctr);
    return c;
  endfunction

  assign centre_ext = {1'b0, centre_r};
  assign hi = centre_ext + {{(jamc_pkg::CMP_W-jamc_pkg::DBAND_W){1'b0}}, dband_r};

  always_comb begin
    cls_in.start      = in_start_pressed;
    cls_in.sel        = in_select_pressed;
    cls_in.l2_press   = in_left_trigger_pressed;
    cls_in.r2_press   = in_right_trigger_pressed;
    cls_in.l2_release = in_left_trigger_released;
    cls_in.r2_release = in_right_trigger_released;
    cls_in.lx         = classify(in_left_x,  hi, centre_ext, dband_r);
    cls_in.rx         = classify(in_right_x, hi, centre_ext, dband_r);
    cls_in.ly         = classify(in_left_y,  hi, centre_ext, dband_r);
    cls_in.ry         = classify(in_right_y, hi, centre_ext, dband_r);
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign cls_valid = (cnt_r != 2'd0);
  assign cls_word  = q_r[rp_r];
  assign cnt_nxt   = cnt_r + {1'b0, push_ok} - {1'b0, cls_take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_r <= ~wp_r;
      end
      if (cls_take) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= cls_in;
    end
  end

endmodule

@@ hw/rtl/jamc_back.sv @@
module jamc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cls_valid,
  input  jamc_pkg::cls_t cls_word,
  output logic           cls_take,
  output logic           out_empty,
  input  logic           out_pop,
  output jamc_pkg::res_t res_word
);

  jamc_pkg::mode_t mode_r;
  jamc_pkg::mode_t mode_nxt;
  jamc_pkg::led_t  green_r;
  jamc_pkg::led_t  green_nxt;
  jamc_pkg::led_t  yellow_r;
  jamc_pkg::led_t  yellow_nxt;
  jamc_pkg::led_t  red_r;
  jamc_pkg::led_t  red_nxt;
  jamc_pkg::res_t  res_new;

  jamc_pkg::res_t  q_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;
  logic            pop_ok;

  assign cls_take = cls_valid && (cnt_r != 2'd2);

  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      jamc_pkg::MODE_INIT: begin
        if (cls_word.start) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_READY: begin
        if (cls_word.sel)           mode_nxt = jamc_pkg::MODE_INIT;
        else if (cls_word.l2_press) mode_nxt = jamc_pkg::MODE_OPEN;
        else if (cls_word.r2_press) mode_nxt = jamc_pkg::MODE_CLOSE;
        else if (cls_word.lx.ge_hi) mode_nxt = jamc_pkg::MODE_RIGHT;
        else if (cls_word.lx.le_lo) mode_nxt = jamc_pkg::MODE_LEFT;
        else if (cls_word.rx.ge_hi) mode_nxt = jamc_pkg::MODE_FRONT_UP;
        else if (cls_word.rx.le_lo) mode_nxt = jamc_pkg::MODE_FRONT_DOWN;
        else if (cls_word.ly.ge_hi) mode_nxt = jamc_pkg::MODE_REAR_DOWN;
        else if (cls_word.ly.le_lo) mode_nxt = jamc_pkg::MODE_REAR_UP;
        else if (cls_word.ry.ge_hi) mode_nxt = jamc_pkg::MODE_MID_DOWN;
        else if (cls_word.ry.le_lo) mode_nxt = jamc_pkg::MODE_MID_UP;
      end
      jamc_pkg::MODE_LEFT: begin
        if (!cls_word.lx.le_lo) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_RIGHT: begin
        if (!cls_word.lx.ge_hi) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_REAR_UP: begin
        if (!cls_word.ly.le_lo) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_REAR_DOWN: begin
        if (!cls_word.ly.ge_hi) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_MID_UP: begin
        if (!cls_word.ry.le_lo) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_MID_DOWN: begin
        if (!cls_word.ry.ge_hi) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_FRONT_UP: begin
        if (!cls_word.rx.ge_hi) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_FRONT_DOWN: begin
        if (!cls_word.rx.le_lo) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_CLOSE: begin
        if (cls_word.r2_release) mode_nxt = jamc_pkg::MODE_READY;
      end
      jamc_pkg::MODE_OPEN: begin
        if (cls_word.l2_release) mode_nxt = jamc_pkg::MODE_READY;
      end
      default: mode_nxt = mode_r;
    endcase
  end

  // exit action of the old mode, then entry action of the new one
  always_comb begin
    green_nxt  = green_r;
    yellow_nxt = yellow_r;
    red_nxt    = red_r;
    if (mode_nxt != mode_r) begin
      unique case (mode_r)
        jamc_pkg::MODE_INIT: begin
          green_nxt  = jamc_pkg::LED_OFF;
          yellow_nxt = jamc_pkg::LED_OFF;
          red_nxt    = jamc_pkg::LED_OFF;
        end
        jamc_pkg::MODE_READY: begin
          green_nxt = jamc_pkg::LED_OFF;
        end
        default: begin
          green_nxt  = jamc_pkg::LED_OFF;
          yellow_nxt = jamc_pkg::LED_OFF;
        end
      endcase
      unique case (mode_nxt)
        jamc_pkg::MODE_INIT: begin
          green_nxt  = jamc_pkg::LED_FLASH;
          yellow_nxt = jamc_pkg::LED_FLASH;
          red_nxt    = jamc_pkg::LED_FLASH;
        end
        jamc_pkg::MODE_READY: begin
          green_nxt = jamc_pkg::LED_ON;
        end
        jamc_pkg::MODE_CLOSE, jamc_pkg::MODE_OPEN: begin
          green_nxt  = jamc_pkg::LED_ON;
          yellow_nxt = jamc_pkg::LED_FLASH;
        end
        default: begin
          green_nxt  = jamc_pkg::LED_ON;
          yellow_nxt = jamc_pkg::LED_ON;
        end
      endcase
    end
  end

  always_comb begin
    res_new.mode         = mode_nxt;
    res_new.base_motor   = jamc_pkg::MOTOR_STOP;
    res_new.rear_motor   = jamc_pkg::MOTOR_STOP;
    res_new.middle_motor = jamc_pkg::MOTOR_STOP;
    res_new.front_motor  = jamc_pkg::MOTOR_STOP;
    res_new.gripper_cmd  = jamc_pkg::GRIP_NONE;
    res_new.green_led    = green_nxt;
    res_new.yellow_led   = yellow_nxt;
    res_new.red_led      = red_nxt;
    unique case (mode_nxt)
      jamc_pkg::MODE_LEFT:       res_new.base_motor   = jamc_pkg::MOTOR_LEFT;
      jamc_pkg::MODE_RIGHT:      res_new.base_motor   = jamc_pkg::MOTOR_RIGHT;
      jamc_pkg::MODE_REAR_UP:    res_new.rear_motor   = jamc_pkg::MOTOR_LEFT;
      jamc_pkg::MODE_REAR_DOWN:  res_new.rear_motor   = jamc_pkg::MOTOR_RIGHT;
      jamc_pkg::MODE_MID_UP:     res_new.middle_motor = jamc_pkg::MOTOR_LEFT;
      jamc_pkg::MODE_MID_DOWN:   res_new.middle_motor = jamc_pkg::MOTOR_RIGHT;
      jamc_pkg::MODE_FRONT_UP:   res_new.front_motor  = jamc_pkg::MOTOR_LEFT;
      jamc_pkg::MODE_FRONT_DOWN: res_new.front_motor  = jamc_pkg::MOTOR_RIGHT;
      jamc_pkg::MODE_CLOSE:      res_new.gripper_cmd  = jamc_pkg::GRIP_CLOSE;
      jamc_pkg::MODE_OPEN:       res_new.gripper_cmd  = jamc_pkg::GRIP_OPEN;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= jamc_pkg::MODE_INIT;
      green_r  <= jamc_pkg::LED_OFF;
      yellow_r <= jamc_pkg::LED_OFF;
      red_r    <= jamc_pkg::LED_OFF;
    end else if (cls_take) begin
      mode_r   <= mode_nxt;
      green_r  <= green_nxt;
      yellow_r <= yellow_nxt;
      red_r    <= red_nxt;
    end
  end

  assign out_empty = (cnt_r == 2'd0);
  assign pop_ok    = out_pop && !out_empty;
  assign res_word  = q_r[rp_r];
  assign cnt_nxt   = cnt_r + {1'b0, cls_take} - {1'b0, pop_ok};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (cls_take) begin
        wp_r <= ~wp_r;
      end
      if (pop_ok) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cls_take) begin
      q_r[wp_r] <= res_new;
    end
  end

endmodule

@@ hw/rtl/joystick_arm_mode_controller_core.sv @@
// channel   handshake               payload
// in        in_push / in_full       button edges, four stick axes
// out       out_empty / out_pop     mode, four motor codes, gripper, three LED modes
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (0 centre, 1 deadband)
//
// One poll per cycle sustained while out is popped; a poll is registered in both queues.
// The front classifies the axes into a two-entry queue; the back steps the mode
// machine into a two-entry result queue. cfg_ready is always high.
// Synchronous active-low reset empties both queues, sets mode init, LEDs off,
// centre 128 and deadband 20. A stalled out side fills both queues, then raises in_full.
module joystick_arm_mode_controller_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jamc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jamc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_start_pressed,
  input  logic                            in_select_pressed,
  input  logic                            in_left_trigger_pressed,
  input  logic                            in_right_trigger_pressed,
  input  logic                            in_left_trigger_released,
  input  logic                            in_right_trigger_released,
  input  logic [jamc_pkg::AXIS_W-1:0]     in_left_x,
  input  logic [jamc_pkg::AXIS_W-1:0]     in_right_x,
  input  logic [jamc_pkg::AXIS_W-1:0]     in_left_y,
  input  logic [jamc_pkg::AXIS_W-1:0]     in_right_y,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [3:0]                      out_mode,
  output logic [1:0]                      out_base_motor,
  output logic [1:0]                      out_rear_motor,
  output logic [1:0]                      out_middle_motor,
  output logic [1:0]                      out_front_motor,
  output logic [1:0]                      out_gripper_cmd,
  output logic [1:0]                      out_green_led,
  output logic [1:0]                      out_yellow_led,
  output logic [1:0]                      out_red_led
);

  logic           cls_valid;
  logic           cls_take;
  jamc_pkg::cls_t cls_word;
  jamc_pkg::res_t res_word;

  jamc_front u_front (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data),
    .in_push                   (in_push),
    .in_full                   (in_full),
    .in_start_pressed          (in_start_pressed),
    .in_select_pressed         (in_select_pressed),
    .in_left_trigger_pressed   (in_left_trigger_pressed),
    .in_right_trigger_pressed  (in_right_trigger_pressed),
    .in_left_trigger_released  (in_left_trigger_released),
    .in_right_trigger_released (in_right_trigger_released),
    .in_left_x                 (in_left_x),
    .in_right_x                (in_right_x),
    .in_left_y                 (in_left_y),
    .in_right_y                (in_right_y),
    .cls_valid                 (cls_valid),
    .cls_word                  (cls_word),
    .cls_take                  (cls_take)
  );

  jamc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (cls_valid),
    .cls_word  (cls_word),
    .cls_take  (cls_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res_word  (res_word)
  );

  assign out_mode         = res_word.mode;
  assign out_base_motor   = res_word.base_motor;
  assign out_rear_motor   = res_word.rear_motor;
  assign out_middle_motor = res_word.middle_motor;
  assign out_front_motor  = res_word.front_motor;
  assign out_gripper_cmd  = res_word.gripper_cmd;
  assign out_green_led    = res_word.green_led;
  assign out_yellow_led   = res_word.yellow_led;
  assign out_red_led      = res_word.red_led;

endmodule

@@ tb/jamc_mode_checker.sv @@
`timescale 1ns / 100ps

module jamc_mode_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [jamc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jamc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_push,
  input  logic                            in_full,
  input  logic                            in_start_pressed,
  input  logic                            in_select_pressed,
  input  logic                            in_left_trigger_pressed,
  input  logic                            in_right_trigger_pressed,
  input  logic                            in_left_trigger_released,
  input  logic                            in_right_trigger_released,
  input  logic [jamc_pkg::AXIS_W-1:0]     in_left_x,
  input  logic [jamc_pkg::AXIS_W-1:0]     in_right_x,
  input  logic [jamc_pkg::AXIS_W-1:0]     in_left_y,
  input  logic [jamc_pkg::AXIS_W-1:0]     in_right_y,
  input  logic                            out_empty,
  input  logic                            out_pop,
  input  logic [3:0]                      out_mode,
  input  logic [1:0]                      out_base_motor,
  input  logic [1:0]                      out_rear_motor,
  input  logic [1:0]                      out_middle_motor,
  input  logic [1:0]                      out_front_motor,
  input  logic [1:0]                      out_gripper_cmd,
  input  logic [1:0]                      out_green_led,
  input  logic [1:0]                      out_yellow_led,
  input  logic [1:0]                      out_red_led,
  output int                              err_count,
  output int                              pending,
  output int                              checked,
  output logic [11:0]                     modes_seen
);
  import jamc_pkg::*;

  logic [CENTRE_W-1:0] centre_q;
  logic [DBAND_W-1:0]  dband_q;
  mode_t               arm_mode;
  led_t                green_q;
  led_t                yellow_q;
  led_t                red_q;
  res_t                predicted_words[$];
  int                  n_err = 0;
  int                  n_checked = 0;
  logic [11:0]         seen = '0;

  assign err_count  = n_err;
  assign checked    = n_checked;
  assign modes_seen = seen;

  initial pending = 0;

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic res_t step_arm_mode(input logic start, sel, l2p, r2p, l2r, r2r,
                                         input logic [AXIS_W-1:0] lx_b, rx_b, ly_b, ry_b);
    int    hi;
    int    lo;
    int    lx;
    int    rx;
    int    ly;
    int    ry;
    mode_t nxt;
    res_t  w;
    hi = int'(centre_q) + int'(dband_q);
    lo = int'(centre_q) - int'(dband_q);
    lx = int'(lx_b);
    rx = int'(rx_b);
    ly = int'(ly_b);
    ry = int'(ry_b);
    nxt = arm_mode;
    case (arm_mode)
      MODE_INIT: if (start) nxt = MODE_READY;
      MODE_READY: begin
        if (sel) nxt = MODE_INIT;
        else if (l2p) nxt = MODE_OPEN;
        else if (r2p) nxt = MODE_CLOSE;
        else if (lx >= hi) nxt = MODE_RIGHT;
        else if (lx <= lo) nxt = MODE_LEFT;
        else if (rx >= hi) nxt = MODE_FRONT_UP;
        else if (rx <= lo) nxt = MODE_FRONT_DOWN;
        else if (ly >= hi) nxt = MODE_REAR_DOWN;
        else if (ly <= lo) nxt = MODE_REAR_UP;
        else if (ry >= hi) nxt = MODE_MID_DOWN;
        else if (ry <= lo) nxt = MODE_MID_UP;
      end
      MODE_LEFT:       if (lx > lo) nxt = MODE_READY;
      MODE_RIGHT:      if (lx < hi) nxt = MODE_READY;
      MODE_REAR_UP:    if (ly > lo) nxt = MODE_READY;
      MODE_REAR_DOWN:  if (ly < hi) nxt = MODE_READY;
      MODE_MID_UP:     if (ry > lo) nxt = MODE_READY;
      MODE_MID_DOWN:   if (ry < hi) nxt = MODE_READY;
      MODE_FRONT_UP:   if (rx < hi) nxt = MODE_READY;
      MODE_FRONT_DOWN: if (rx > lo) nxt = MODE_READY;
      MODE_CLOSE:      if (r2r) nxt = MODE_READY;
      MODE_OPEN:       if (l2r) nxt = MODE_READY;
      default: ;
    endcase

    if (nxt != arm_mode) begin
      case (arm_mode)
        MODE_INIT: begin
          green_q  = LED_OFF;
          yellow_q = LED_OFF;
          red_q    = LED_OFF;
        end
        MODE_READY: green_q = LED_OFF;
        default: begin
          green_q  = LED_OFF;
          yellow_q = LED_OFF;
        end
      endcase
      case (nxt)
        MODE_INIT: begin
          green_q  = LED_FLASH;
          yellow_q = LED_FLASH;
          red_q    = LED_FLASH;
        end
        MODE_READY: green_q = LED_ON;
        MODE_CLOSE, MODE_OPEN: begin
          green_q  = LED_ON;
          yellow_q = LED_FLASH;
        end
        default: begin
          green_q  = LED_ON;
          yellow_q = LED_ON;
        end
      endcase
      arm_mode = nxt;
    end

    w.mode         = arm_mode;
    w.base_motor   = MOTOR_STOP;
    w.rear_motor   = MOTOR_STOP;
    w.middle_motor = MOTOR_STOP;
    w.front_motor  = MOTOR_STOP;
    w.gripper_cmd  = GRIP_NONE;
    case (arm_mode)
      MODE_LEFT:       w.base_motor   = MOTOR_LEFT;
      MODE_RIGHT:      w.base_motor   = MOTOR_RIGHT;
      MODE_REAR_UP:    w.rear_motor   = MOTOR_LEFT;
      MODE_REAR_DOWN:  w.rear_motor   = MOTOR_RIGHT;
      MODE_MID_UP:     w.middle_motor = MOTOR_LEFT;
      MODE_MID_DOWN:   w.middle_motor = MOTOR_RIGHT;
      MODE_FRONT_UP:   w.front_motor  = MOTOR_LEFT;
      MODE_FRONT_DOWN: w.front_motor  = MOTOR_RIGHT;
      MODE_CLOSE:      w.gripper_cmd  = GRIP_CLOSE;
      MODE_OPEN:       w.gripper_cmd  = GRIP_OPEN;
      default: ;
    endcase
    w.green_led  = green_q;
    w.yellow_led = yellow_q;
    w.red_led    = red_q;
    return w;
  endfunction

  always @(posedge clk) begin : track
    res_t want;
    if (!rst_n) begin
      centre_q = CENTRE_RESET;
      dband_q  = DBAND_RESET;
      arm_mode = MODE_INIT;
      green_q  = LED_OFF;
      yellow_q = LED_OFF;
      red_q    = LED_OFF;
      predicted_words.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (predicted_words.size() == 0) begin
          n_err++;
          $display("%0t: result word with nothing expected, expected none, actual mode %0d",
                   $time, out_mode);
        end else begin
          want = predicted_words.pop_front();
          check_field("mode", want.mode, out_mode);
          check_field("base_motor", want.base_motor, out_base_motor);
          check_field("rear_motor", want.rear_motor, out_rear_motor);
          check_field("middle_motor", want.middle_motor, out_middle_motor);
          check_field("front_motor", want.front_motor, out_front_motor);
          check_field("gripper_cmd", want.gripper_cmd, out_gripper_cmd);
          check_field("green_led", want.green_led, out_green_led);
          check_field("yellow_led", want.yellow_led, out_yellow_led);
          check_field("red_led", want.red_led, out_red_led);
          n_checked++;
          seen[want.mode] = 1'b1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STICK_CENTRE: centre_q = cfg_data[CENTRE_W-1:0];
          CFG_DEADBAND:     dband_q  = cfg_data[DBAND_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        predicted_words.push_back(step_arm_mode(
          in_start_pressed, in_select_pressed, in_left_trigger_pressed,
          in_right_trigger_pressed, in_left_trigger_released, in_right_trigger_released,
          in_left_x, in_right_x, in_left_y, in_right_y));
      end
    end
    pending <= predicted_words.size();
  end

endmodule

@@ tb/joystick_arm_mode_controller_core_tb.sv @@
`timescale 1ns / 100ps

module joystick_arm_mode_controller_core_tb;
  import jamc_pkg::*;

  localparam int LIMIT             = 200000;
  localparam int ITEMS_PER_SETTING = 105;
  localparam int HOLD_CYCLES       = 60;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [5:0] BTN_NONE    = 6'b000000;
  localparam logic [5:0] BTN_START   = 6'b100000;
  localparam logic [5:0] BTN_SELECT  = 6'b010000;
  localparam logic [5:0] BTN_L2_DOWN = 6'b001000;
  localparam logic [5:0] BTN_R2_DOWN = 6'b000100;
  localparam logic [5:0] BTN_L2_UP   = 6'b000010;
  localparam logic [5:0] BTN_R2_UP   = 6'b000001;

  localparam logic [7:0] REST    = CENTRE_RESET;
  localparam logic [7:0] UP_AT   = CENTRE_RESET + 8'(DBAND_RESET);
  localparam logic [7:0] DOWN_AT = CENTRE_RESET - 8'(DBAND_RESET);

  typedef struct packed {
    logic       start;
    logic       sel;
    logic       l2p;
    logic       r2p;
    logic       l2r;
    logic       r2r;
    logic [7:0] lx;
    logic [7:0] rx;
    logic [7:0] ly;
    logic [7:0] ry;
  } poll_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic                  in_start_pressed = 1'b0;
  logic                  in_select_pressed = 1'b0;
  logic                  in_left_trigger_pressed = 1'b0;
  logic                  in_right_trigger_pressed = 1'b0;
  logic                  in_left_trigger_released = 1'b0;
  logic                  in_right_trigger_released = 1'b0;
  logic [AXIS_W-1:0]     in_left_x = '0;
  logic [AXIS_W-1:0]     in_right_x = '0;
  logic [AXIS_W-1:0]     in_left_y = '0;
  logic [AXIS_W-1:0]     in_right_y = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [3:0]            out_mode;
  logic [1:0]            out_base_motor;
  logic [1:0]            out_rear_motor;
  logic [1:0]            out_middle_motor;
  logic [1:0]            out_front_motor;
  logic [1:0]            out_gripper_cmd;
  logic [1:0]            out_green_led;
  logic [1:0]            out_yellow_led;
  logic [1:0]            out_red_led;

  int          err_count;
  int          pending;
  int          checked;
  logic [11:0] modes_seen;

  int cycles = 0;
  int tx_idle_pct = 36;
  int rx_idle_pct = 46;
  int hold_left = 0;
  int n_sent = 0;
  int n_full = 0;
  int n_settings = 0;
  int stick_mid = 128;
  int stick_band = 20;

  joystick_arm_mode_controller_core i_dut (.*);

  jamc_mode_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    out_pop <= rst_n && (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic poll_t pad(input logic [5:0] btn, input logic [7:0] lx, rx, ly, ry);
    return {btn, lx, rx, ly, ry};
  endfunction

  function automatic logic [7:0] rand_axis();
    int hi;
    int lo;
    int a;
    int b;
    int v;
    hi = stick_mid + stick_band;
    lo = stick_mid - stick_band;
    a  = (lo + 1 < 0) ? 0 : lo + 1;
    b  = (hi - 1 > 255) ? 255 : hi - 1;
    case ($urandom_range(11))
      5:       v = hi;
      6:       v = lo;
      7:       v = hi - 1;
      8:       v = lo + 1;
      9, 10:   v = $urandom_range(255);
      11:      v = ($urandom_range(1) != 0) ? 255 : 0;
      default: v = (a <= b) ? $urandom_range(b, a) : stick_mid;
    endcase
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic poll_t rand_poll(input poll_t last);
    poll_t p;
    if ($urandom_range(19) == 0) begin
      {p.start, p.sel, p.l2p, p.r2p, p.l2r, p.r2r} = 6'($urandom_range(63));
      p.lx = 8'($urandom_range(255));
      p.rx = 8'($urandom_range(255));
      p.ly = 8'($urandom_range(255));
      p.ry = 8'($urandom_range(255));
    end else begin
      p.start = ($urandom_range(99) < 15);
      p.sel   = ($urandom_range(99) < 6);
      p.l2p   = ($urandom_range(99) < 10);
      p.r2p   = ($urandom_range(99) < 10);
      p.l2r   = ($urandom_range(99) < 20);
      p.r2r   = ($urandom_range(99) < 20);
      p.lx    = ($urandom_range(1) != 0) ? last.lx : rand_axis();
      p.rx    = ($urandom_range(1) != 0) ? last.rx : rand_axis();
      p.ly    = ($urandom_range(1) != 0) ? last.ly : rand_axis();
      p.ry    = ($urandom_range(1) != 0) ? last.ry : rand_axis();
    end
    return p;
  endfunction

  task automatic send(input poll_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push                   <= 1'b1;
    in_start_pressed          <= p.start;
    in_select_pressed         <= p.sel;
    in_left_trigger_pressed   <= p.l2p;
    in_right_trigger_pressed  <= p.r2p;
    in_left_trigger_released  <= p.l2r;
    in_right_trigger_released <= p.r2r;
    in_left_x                 <= p.lx;
    in_right_x                <= p.rx;
    in_left_y                 <= p.ly;
    in_right_y                <= p.ry;
    do begin
      @(posedge clk);
      if (in_full) n_full++;
    end while (in_full);
    n_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_sticks(input int mid, input int band);
    logic spare_bit;
    spare_bit = $urandom_range(1);
    write_reg(CFG_STICK_CENTRE, mid[7:0]);
    write_reg(CFG_DEADBAND, {spare_bit, band[6:0]});
    write_reg(($urandom_range(1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, 8'($urandom_range(255)));
    cfg_valid <= 1'b0;
    stick_mid  = mid;
    stick_band = band;
    n_settings++;
  endtask

  task automatic settle();
    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int    mids[6];
    int    bands[6];
    poll_t last;
    mids  = '{128, 255, 0, 128, 60, 0};
    bands = '{20, 0, 127, 0, 8, 0};
    mids[5]  = $urandom_range(255);
    bands[5] = $urandom_range(127);
    last = pad(BTN_NONE, REST, REST, REST, REST);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send(pad(BTN_NONE, 8'd0, 8'd255, 8'd0, 8'd255));
    send(pad(BTN_START, REST, REST, REST, REST));
    send(pad(BTN_SELECT | BTN_L2_DOWN | BTN_R2_DOWN, 8'd255, REST, REST, REST));
    send(pad(BTN_START, REST, REST, REST, REST));
    send(pad(BTN_L2_DOWN | BTN_R2_DOWN, 8'd0, REST, REST, REST));
    send(pad(BTN_R2_UP, REST, REST, REST, REST));
    send(pad(BTN_L2_UP, REST, REST, REST, REST));
    send(pad(BTN_R2_DOWN, 8'd255, REST, REST, REST));
    send(pad(BTN_R2_UP, REST, REST, REST, REST));
    send(pad(BTN_NONE, UP_AT, 8'd0, REST, REST));
    send(pad(BTN_NONE, UP_AT - 8'd1, REST, REST, REST));
    send(pad(BTN_NONE, DOWN_AT, REST, REST, REST));
    send(pad(BTN_NONE, DOWN_AT, REST, REST, REST));
    send(pad(BTN_NONE, DOWN_AT + 8'd1, REST, REST, REST));
    send(pad(BTN_NONE, REST, UP_AT, REST, REST));
    send(pad(BTN_NONE, REST, UP_AT - 8'd1, REST, REST));
    send(pad(BTN_NONE, REST, DOWN_AT, REST, REST));
    send(pad(BTN_NONE, REST, DOWN_AT + 8'd1, REST, REST));
    send(pad(BTN_NONE, REST, REST, 8'd255, REST));
    send(pad(BTN_NONE, REST, REST, UP_AT - 8'd1, REST));
    send(pad(BTN_NONE, REST, REST, 8'd0, REST));
    send(pad(BTN_NONE, REST, REST, DOWN_AT + 8'd1, REST));
    send(pad(BTN_NONE, REST, REST, REST, UP_AT));
    send(pad(BTN_NONE, REST, REST, REST, UP_AT - 8'd1));
    send(pad(BTN_NONE, REST, REST, REST, DOWN_AT));
    send(pad(BTN_NONE, REST, REST, REST, DOWN_AT + 8'd1));

    for (int s = 0; s < 6; s++) begin
      settle();
      if (s == 2) begin
        tx_idle_pct = 46;
        rx_idle_pct <= 36;
      end
      if (s == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      set_sticks(mids[s], bands[s]);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        // stall the result side long enough to back up both queues
        if (s == 4 && i == 30) hold_left <= HOLD_CYCLES;
        last = rand_poll(last);
        send(last);
      end
    end

    settle();
    repeat (4) @(posedge clk);

    $display("Sent %0d polls over %0d stick settings; input held off by full for %0d cycles.",
             n_sent, n_settings, n_full);
    $display("Checked %0d result words, reaching %0d of 12 arm modes.",
             checked, $countones(modes_seen));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
